// ===== design/miau_pkg.sv =====
// ----------------------------------------------------------------------------
// miau_pkg
// Shared types, widths and helpers for the attitude update unit.
// ----------------------------------------------------------------------------
package miau_pkg;

  localparam int MUL_W  = 36;
  localparam int PROD_W = 2 * MUL_W;

  // one product term of the quaternion increment
  typedef struct packed {
    logic [1:0] qsel;
    logic [1:0] hsel;
    logic [1:0] tgt;
    logic       neg;
  } nq_term_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic nq_term_t nq_term(input logic [3:0] t);
    nq_term_t r;
    case (t)
      4'd0:    r = '{qsel: 2'd1, hsel: 2'd0, tgt: 2'd0, neg: 1'b1};
      4'd1:    r = '{qsel: 2'd2, hsel: 2'd1, tgt: 2'd0, neg: 1'b1};
      4'd2:    r = '{qsel: 2'd3, hsel: 2'd2, tgt: 2'd0, neg: 1'b1};
      4'd3:    r = '{qsel: 2'd0, hsel: 2'd0, tgt: 2'd1, neg: 1'b0};
      4'd4:    r = '{qsel: 2'd2, hsel: 2'd2, tgt: 2'd1, neg: 1'b0};
      4'd5:    r = '{qsel: 2'd3, hsel: 2'd1, tgt: 2'd1, neg: 1'b1};
      4'd6:    r = '{qsel: 2'd0, hsel: 2'd1, tgt: 2'd2, neg: 1'b0};
      4'd7:    r = '{qsel: 2'd1, hsel: 2'd2, tgt: 2'd2, neg: 1'b1};
      4'd8:    r = '{qsel: 2'd3, hsel: 2'd0, tgt: 2'd2, neg: 1'b0};
      4'd9:    r = '{qsel: 2'd0, hsel: 2'd2, tgt: 2'd3, neg: 1'b0};
      4'd10:   r = '{qsel: 2'd1, hsel: 2'd1, tgt: 2'd3, neg: 1'b0};
      4'd11:   r = '{qsel: 2'd2, hsel: 2'd0, tgt: 2'd3, neg: 1'b1};
      default: r = '{qsel: 2'd0, hsel: 2'd0, tgt: 2'd0, neg: 1'b0};
    endcase
    return r;
  endfunction

endpackage

// ===== design/miau_mul.sv =====
// ----------------------------------------------------------------------------
// miau_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module miau_mul
  import miau_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== design/mahony_imu_attitude_update_unit.sv =====
// ----------------------------------------------------------------------------
// mahony_imu_attitude_update_unit
// Mahony IMU attitude filter step: accel correction, integration, renorm.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel (sample_valid/sample_stall) takes one word of gyro rates,
//   accel counts and interval. Result channel (result_valid/result_stall)
//   returns the quaternion and the updated flag, one word per sample.
//   Config channel (cfg_valid/cfg_ready, always ready) writes the two gains;
//   write only while idle.
// Sequence: one sample runs through a sequencer around a single shared
//   36x36 multiplier. Each vector normalization runs INVSQRT_ITERATIONS
//   inverse square root iterations after its scaling steps. A nonzero
//   accel vector is normalized and drives the correction; integration
//   follows, then the quaternion renormalization and the result load.
//   A zero accel vector goes straight to integration, and a zero
//   interval goes straight to the result load.
// Throughput: one sample at a time; sample_stall is high while busy.
// The result sits in an output register; a stalled result holds the
//   sequencer in its final state until taken.
// Reset: identity quaternion, zero integral, gains 2.0 and 0.
// ----------------------------------------------------------------------------
module mahony_imu_attitude_update_unit
  import miau_pkg::*;
#(
  parameter int INVSQRT_ITERATIONS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic        [20:0] interval,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] quat_w,
  output logic signed [31:0] quat_x,
  output logic signed [31:0] quat_y,
  output logic signed [31:0] quat_z,
  output logic               updated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic        [28:0] cfg_data
);

  localparam int ITW = $clog2(INVSQRT_ITERATIONS + 1);

  localparam logic CFG_PROP  = 1'b0;
  localparam logic CFG_INTEG = 1'b1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_ABS  = 4'd1;
  localparam logic [3:0] ST_SHF  = 4'd2;
  localparam logic [3:0] ST_SQ   = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_NRM  = 4'd5;
  localparam logic [3:0] ST_Y0   = 4'd6;
  localparam logic [3:0] ST_IT   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;
  localparam logic [3:0] ST_RET  = 4'd9;
  localparam logic [3:0] ST_CORR = 4'd10;
  localparam logic [3:0] ST_AXIS = 4'd11;
  localparam logic [3:0] ST_H    = 4'd12;
  localparam logic [3:0] ST_NQ   = 4'd13;
  localparam logic [3:0] ST_FIN  = 4'd14;

  logic [3:0] state;
  logic [4:0] st;
  logic [1:0] idx;
  logic [ITW-1:0] it;
  logic ret, ok, upd;

  logic signed [31:0] q [4];
  logic signed [31:0] integ [3];
  logic [28:0] kp, ki;

  logic signed [39:0] g [3];
  logic [20:0] dt;
  logic signed [39:0] c [4];
  logic [39:0] mag [4];
  logic [39:0] maxm;
  logic [63:0] s, m;
  logic signed [5:0] j;
  logic [31:0] y;
  logic signed [31:0] uo [4];
  logic signed [39:0] vx, vy, vz;
  logic signed [39:0] e [3];
  logic signed [39:0] h [3];
  logic signed [39:0] nq [4];
  logic signed [PROD_W-1:0] acc;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] p;

  logic [39:0] mag_abs [4];
  logic [39:0] max_abs;
  logic [33:0] tt, hh, yi;
  logic [5:0] sh;
  logic [63:0] r;
  logic signed [31:0] rc;
  logic [1:0] oi;
  logic signed [PROD_W-1:0] diff, sum;
  logic signed [39:0] isum;
  logic signed [31:0] inew;
  logic signed [39:0] term;
  nq_term_t tm, tp;

  miau_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign sample_stall = (state != ST_IDLE);
  assign cfg_ready    = 1'b1;

  always_comb begin
    max_abs = '0;
    for (int i = 0; i < 4; i++) begin
      mag_abs[i] = c[i][39] ? 40'(-c[i]) : 40'(c[i]);
      if (mag_abs[i] > max_abs) begin
        max_abs = mag_abs[i];
      end
    end
    tt   = p[63:30];
    hh   = (tt < 34'd3221225472) ? 34'd3221225472 - tt : '0;
    yi   = 34'd2684354560 - ((34'(m[29:0]) * 34'd3) >> 1);
    sh   = 6'(7'sd15 - 7'(j));
    r    = p[63:0] >> sh;
    rc   = (r > 64'd1073741824) ? 32'sd1073741824 : $signed(r[31:0]);
    oi   = 2'(st - 5'd1);
    diff = acc - p;
    sum  = acc + p;
    isum = 40'(integ[idx]) + $signed(p[63:24]);
    inew = sat32(isum);
    term = $signed(p[69:30]);
    tm   = nq_term(st[3:0]);
    tp   = nq_term(4'(st - 5'd1));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = MUL_W'(mag[st[1:0]]);
        mul_b = MUL_W'(mag[st[1:0]]);
      end
      ST_IT: begin
        case (st[1:0])
          2'd0: begin
            mul_a = MUL_W'(y);
            mul_b = MUL_W'(y);
          end
          2'd1: begin
            mul_a = MUL_W'(m[29:0]);
            mul_b = MUL_W'(p[63:30]);
          end
          2'd2: begin
            mul_a = MUL_W'(y);
            mul_b = MUL_W'(hh);
          end
          default: ;
        endcase
      end
      ST_OUT: begin
        mul_a = MUL_W'(mag[st[1:0]]);
        mul_b = MUL_W'(y);
      end
      ST_CORR: begin
        case (st)
          5'd0: begin mul_a = MUL_W'(q[1]); mul_b = MUL_W'(q[3]); end
          5'd1: begin mul_a = MUL_W'(q[0]); mul_b = MUL_W'(q[2]); end
          5'd2: begin mul_a = MUL_W'(q[0]); mul_b = MUL_W'(q[1]); end
          5'd3: begin mul_a = MUL_W'(q[2]); mul_b = MUL_W'(q[3]); end
          5'd4: begin mul_a = MUL_W'(q[0]); mul_b = MUL_W'(q[0]); end
          5'd5: begin mul_a = MUL_W'(q[3]); mul_b = MUL_W'(q[3]); end
          5'd7: begin mul_a = MUL_W'(uo[1]); mul_b = vz[35:0]; end
          5'd8: begin mul_a = MUL_W'(uo[2]); mul_b = vy[35:0]; end
          5'd9: begin mul_a = MUL_W'(uo[2]); mul_b = vx[35:0]; end
          5'd10: begin mul_a = MUL_W'(uo[0]); mul_b = vz[35:0]; end
          5'd11: begin mul_a = MUL_W'(uo[0]); mul_b = vy[35:0]; end
          5'd12: begin mul_a = MUL_W'(uo[1]); mul_b = vx[35:0]; end
          default: ;
        endcase
      end
      ST_AXIS: begin
        case (st[1:0])
          2'd0: begin mul_a = MUL_W'(ki); mul_b = e[idx][35:0]; end
          2'd1: begin mul_a = p[65:30]; mul_b = MUL_W'(dt); end
          2'd2: begin mul_a = MUL_W'(kp); mul_b = e[idx][35:0]; end
          default: ;
        endcase
      end
      ST_H: begin
        mul_a = MUL_W'(sat32(g[st[1:0]]));
        mul_b = MUL_W'(dt);
      end
      ST_NQ: begin
        mul_a = MUL_W'(q[tm.qsel]);
        mul_b = h[tm.hsel][35:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      q[0]         <= 32'sd1073741824;
      q[1]         <= '0;
      q[2]         <= '0;
      q[3]         <= '0;
      integ[0]     <= '0;
      integ[1]     <= '0;
      integ[2]     <= '0;
      kp           <= 29'd33554432;
      ki           <= '0;
    end else begin
      if (result_valid && !result_stall && state != ST_FIN) begin
        result_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PROP:  kp <= cfg_data;
          CFG_INTEG: ki <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            g[0] <= 40'(rate_x);
            g[1] <= 40'(rate_y);
            g[2] <= 40'(rate_z);
            c[0] <= 40'(accel_x);
            c[1] <= 40'(accel_y);
            c[2] <= 40'(accel_z);
            c[3] <= '0;
            dt   <= interval;
            ret  <= 1'b0;
            st   <= '0;
            upd  <= 1'b0;
            if (interval == '0) begin
              state <= ST_FIN;
            end else if (accel_x != '0 || accel_y != '0 || accel_z != '0) begin
              state <= ST_ABS;
            end else begin
              state <= ST_H;
            end
          end
        end
        ST_ABS: begin
          for (int i = 0; i < 4; i++) begin
            mag[i] <= mag_abs[i];
          end
          maxm  <= max_abs;
          state <= ST_SHF;
        end
        ST_SHF: begin
          if (maxm[39:31] != '0) begin
            maxm <= maxm >> 1;
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            s     <= '0;
            st    <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (st != 5'd0) begin
            s <= s + p[63:0];
          end
          if (st == 5'd4) begin
            state <= ST_CHK;
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_CHK: begin
          if (s == '0) begin
            ok    <= 1'b0;
            state <= ST_RET;
          end else begin
            m     <= s;
            j     <= '0;
            state <= ST_NRM;
          end
        end
        ST_NRM: begin
          if (m[63:30] != '0) begin
            m <= m >> 2;
            j <= j - 6'sd1;
          end else if (m[29:28] == 2'd0) begin
            m <= m << 2;
            j <= j + 6'sd1;
          end else begin
            state <= ST_Y0;
          end
        end
        ST_Y0: begin
          y     <= yi[31:0];
          it    <= '0;
          st    <= '0;
          state <= ST_IT;
        end
        ST_IT: begin
          if (st[1:0] == 2'd3) begin
            y  <= p[62:31];
            st <= '0;
            it <= it + 1'b1;
            if (it + 1'b1 == ITW'(INVSQRT_ITERATIONS)) begin
              state <= ST_OUT;
            end
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_OUT: begin
          if (st != 5'd0) begin
            uo[oi] <= c[oi][39] ? -rc : rc;
          end
          if (st == 5'd4) begin
            ok    <= 1'b1;
            state <= ST_RET;
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_RET: begin
          st <= '0;
          if (!ret) begin
            state <= ST_CORR;
          end else begin
            if (ok) begin
              for (int i = 0; i < 4; i++) begin
                q[i] <= uo[i];
              end
              upd <= 1'b1;
            end
            state <= ST_FIN;
          end
        end
        ST_CORR: begin
          case (st)
            5'd1, 5'd3, 5'd5, 5'd8, 5'd10, 5'd12: acc <= p;
            5'd2:  vx <= $signed(diff[69:30]);
            5'd4:  vy <= $signed(sum[69:30]);
            5'd6:  vz <= $signed(sum[69:30]) - 40'sd536870912;
            5'd9:  e[0] <= $signed(diff[69:30]);
            5'd11: e[1] <= $signed(diff[69:30]);
            5'd13: e[2] <= $signed(diff[69:30]);
            default: ;
          endcase
          if (st == 5'd13) begin
            st    <= '0;
            idx   <= '0;
            state <= ST_AXIS;
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_AXIS: begin
          case (st[1:0])
            2'd2: begin
              if (ki != '0) begin
                integ[idx] <= inew;
                g[idx]     <= g[idx] + 40'(inew);
              end else begin
                integ[idx] <= '0;
              end
            end
            2'd3: g[idx] <= g[idx] + term;
            default: ;
          endcase
          if (st[1:0] == 2'd3) begin
            st <= '0;
            if (idx == 2'd2) begin
              state <= ST_H;
            end else begin
              idx <= idx + 2'd1;
            end
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_H: begin
          if (st != 5'd0) begin
            h[oi] <= $signed(p[58:19]);
          end
          if (st == 5'd3) begin
            for (int i = 0; i < 4; i++) begin
              nq[i] <= 40'(q[i]);
            end
            st    <= '0;
            state <= ST_NQ;
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_NQ: begin
          if (st != 5'd0 && st != 5'd13) begin
            nq[tp.tgt] <= tp.neg ? nq[tp.tgt] - term : nq[tp.tgt] + term;
          end
          if (st == 5'd13) begin
            for (int i = 0; i < 4; i++) begin
              c[i] <= nq[i];
            end
            ret   <= 1'b1;
            state <= ST_ABS;
          end else begin
            st <= st + 5'd1;
          end
        end
        ST_FIN: begin
          if (!result_valid || !result_stall) begin
            quat_w       <= q[0];
            quat_x       <= q[1];
            quat_y       <= q[2];
            quat_z       <= q[3];
            updated      <= upd;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
